@@ sv/rme_pkg.sv @@
// shared constants and the arctangent table for the rotation matrix to euler block
package rme_pkg;

  // cordic datapath widths
  localparam int CORDIC_STAGES = 24;
  localparam int ANGLE_FRAC    = 24;
  localparam int CW            = 56;
  localparam int ZW            = 32;
  localparam int PRESHIFT_BASE = 52;

  // pi in units of 2^-24 rad
  localparam logic signed [ZW-1:0] PI_Q24 = 32'sd52707179;

  // configuration port
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int THRESH_W   = 15;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd1;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd13176795;
      1:  v = 32'sd7778716;
      2:  v = 32'sd4110060;
      3:  v = 32'sd2086331;
      4:  v = 32'sd1047214;
      5:  v = 32'sd524117;
      6:  v = 32'sd262123;
      7:  v = 32'sd131069;
      8:  v = 32'sd65536;
      9:  v = 32'sd32768;
      10: v = 32'sd16384;
      11: v = 32'sd8192;
      12: v = 32'sd4096;
      13: v = 32'sd2048;
      14: v = 32'sd1024;
      15: v = 32'sd512;
      16: v = 32'sd256;
      17: v = 32'sd128;
      18: v = 32'sd64;
      19: v = 32'sd32;
      20: v = 32'sd16;
      21: v = 32'sd8;
      22: v = 32'sd4;
      23: v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ sv/rme_sqrt.sv @@
// pipelined sum of squares and digit-by-digit integer square root
module rme_sqrt #(
  parameter int W  = 16,
  parameter int PW = 112
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic [PW-1:0]       pay_i,
  output logic [W-1:0]        root_o,
  output logic [PW-1:0]       pay_o
);

  localparam int NW = 2 * W;

  logic [NW-1:0] sqa_r, sqb_r, n_r [0:W], q_r [0:W];
  logic [PW-1:0] pay0_r, pay_r [0:W];

  // squares
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r  <= NW'(a * a);
      sqb_r  <= NW'(b * b);
      pay0_r <= pay_i;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= sqa_r + sqb_r;
      q_r[0]   <= '0;
      pay_r[0] <= pay0_r;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < W; k++) begin : g_it
    localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << (2 * (W - 1 - k));
    logic [NW-1:0] trial, n_nxt, q_nxt;
    always_comb begin
      trial = q_r[k] + BIT;
      if (n_r[k] >= trial) begin
        n_nxt = n_r[k] - trial;
        q_nxt = (q_r[k] >> 1) + BIT;
      end else begin
        n_nxt = n_r[k];
        q_nxt = q_r[k] >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]   <= n_nxt;
        q_r[k+1]   <= q_nxt;
        pay_r[k+1] <= pay_r[k];
      end
    end
  end

  assign root_o = q_r[W][W-1:0];
  assign pay_o  = pay_r[W];

endmodule

@@ sv/rme_cordic.sv @@
// pipelined vectoring cordic atan2 with output rounding
module rme_cordic #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W:0]   y_i,
  input  logic signed [W:0]   x_i,
  output logic signed [W-1:0] angle_o
);

  localparam int CW = rme_pkg::CW;
  localparam int ZW = rme_pkg::ZW;
  localparam int NS = rme_pkg::CORDIC_STAGES;
  localparam int SH = rme_pkg::PRESHIFT_BASE - W;

  logic signed [CW-1:0] xs_r [0:NS];
  logic signed [CW-1:0] ys_r [0:NS];
  logic signed [ZW-1:0] z_r  [0:NS];
  logic signed [W-1:0]  angle_r;

  // half-plane fold and preshift
  logic signed [CW-1:0] xe, ye, xs_nxt, ys_nxt;
  logic signed [ZW-1:0] z_nxt;
  always_comb begin
    xe = CW'(x_i) <<< SH;
    ye = CW'(y_i) <<< SH;
    if (x_i < 0) begin
      xs_nxt = -xe;
      ys_nxt = -ye;
      z_nxt  = (y_i >= 0) ? rme_pkg::PI_Q24 : -rme_pkg::PI_Q24;
    end else begin
      xs_nxt = xe;
      ys_nxt = ye;
      z_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r[0] <= xs_nxt;
      ys_r[0] <= ys_nxt;
      z_r[0]  <= z_nxt;
    end
  end

  // micro-rotations, frozen once y reaches zero
  for (genvar i = 0; i < NS; i++) begin : g_st
    localparam logic signed [ZW-1:0] ANG = rme_pkg::atan_q24(i);
    logic signed [CW-1:0] dx, dy, xn, yn;
    logic signed [ZW-1:0] zn;
    always_comb begin
      dx = ys_r[i] >>> i;
      dy = xs_r[i] >>> i;
      if (ys_r[i] == 0) begin
        xn = xs_r[i];
        yn = ys_r[i];
        zn = z_r[i];
      end else if (ys_r[i] > 0) begin
        xn = xs_r[i] + dx;
        yn = ys_r[i] - dy;
        zn = z_r[i] + ANG;
      end else begin
        xn = xs_r[i] - dx;
        yn = ys_r[i] + dy;
        zn = z_r[i] - ANG;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xs_r[i+1] <= xn;
        ys_r[i+1] <= yn;
        z_r[i+1]  <= zn;
      end
    end
  end

  // scale to the output format
  logic signed [ZW-1:0] zq;
  if (W - 3 < rme_pkg::ANGLE_FRAC) begin : g_rnd
    localparam int S = rme_pkg::ANGLE_FRAC - (W - 3);
    localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (S - 1);
    assign zq = (z_r[NS] + HALF) >>> S;
  end else begin : g_lsh
    assign zq = z_r[NS] <<< (W - 3 - rme_pkg::ANGLE_FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zq[W-1:0];
    end
  end

  assign angle_o = angle_r;

endmodule

@@ sv/rotation_matrix_to_euler.sv @@
// top level: rotation matrix to x-y-z euler angles, fixed point pipeline
// Takes one matrix word per clock and returns angle_x, angle_y, angle_z (Q3.(W-3) rad) and the
// singular flag: a squares stage and a sum stage form r00^2+r10^2, DATA_WIDTH stages
// take the square root one bit each, one stage compares sy to the threshold register and picks the
// operands, and three parallel 24-stage CORDIC units (plus fold and rounding stages) give
// the angles. Throughput is one word per cycle; the whole pipeline holds while a finished
// result waits on out_stall. The threshold sits at byte address 0 of the APB port.
module rotation_matrix_to_euler #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [DATA_WIDTH-1:0]       in_r00,
  input  logic signed [DATA_WIDTH-1:0]       in_r10,
  input  logic signed [DATA_WIDTH-1:0]       in_r20,
  input  logic signed [DATA_WIDTH-1:0]       in_r21,
  input  logic signed [DATA_WIDTH-1:0]       in_r22,
  input  logic signed [DATA_WIDTH-1:0]       in_r11,
  input  logic signed [DATA_WIDTH-1:0]       in_r12,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [DATA_WIDTH-1:0]       out_angle_x,
  output logic signed [DATA_WIDTH-1:0]       out_angle_y,
  output logic signed [DATA_WIDTH-1:0]       out_angle_z,
  output logic                               out_singular,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rme_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [rme_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [rme_pkg::PDATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 5 * W;
  localparam int CL  = rme_pkg::CORDIC_STAGES + 2;
  localparam int L   = W + 3 + CL;
  localparam int TW  = rme_pkg::THRESH_W;

  // configuration register
  logic [TW-1:0] thresh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= rme_pkg::THRESH_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == rme_pkg::REG_THRESHOLD) begin
      thresh_r <= cfg_pwdata[TW-1:0];
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rme_pkg::REG_THRESHOLD) ?
                      {{(rme_pkg::PDATA_W-TW){1'b0}}, thresh_r} : '0;

  // global advance: hold everything while the output word waits
  logic en;
  logic [L-1:0] v_r;
  assign en       = !v_r[L-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[L-2:0], in_valid};
    end
  end

  // sy and matrix entries carried alongside
  logic [W-1:0]  sy;
  logic [PW-1:0] pay_d;
  logic signed [W-1:0] d_r20, d_r21, d_r22, d_r11, d_r12;
  rme_sqrt #(.W(W), .PW(PW)) u_sqrt (
    .clk    (clk),
    .en     (en),
    .a      (in_r00),
    .b      (in_r10),
    .pay_i  ({in_r20, in_r21, in_r22, in_r11, in_r12}),
    .root_o (sy),
    .pay_o  (pay_d)
  );
  assign {d_r20, d_r21, d_r22, d_r11, d_r12} = pay_d;

  // r10 and r00 also travel with the root
  logic signed [W-1:0] r10_d_r [0:W+1];
  logic signed [W-1:0] r00_d_r [0:W+1];
  always_ff @(posedge clk) begin
    if (en) begin
      r10_d_r[0] <= in_r10;
      r00_d_r[0] <= in_r00;
      for (int k = 1; k < W + 2; k++) begin
        r10_d_r[k] <= r10_d_r[k-1];
        r00_d_r[k] <= r00_d_r[k-1];
      end
    end
  end

  // branch decision and operand select
  logic sing;
  logic signed [W:0] xa_y_r, xa_x_r, ya_y_r, ya_x_r, za_y_r, za_x_r;
  logic sing_r;
  assign sing = {{(33-W){1'b0}}, sy} < {{(33-TW){1'b0}}, thresh_r};
  always_ff @(posedge clk) begin
    if (en) begin
      sing_r <= sing;
      xa_y_r <= sing ? -(W+1)'(d_r12) : (W+1)'(d_r21);
      xa_x_r <= sing ? (W+1)'(d_r11) : (W+1)'(d_r22);
      ya_y_r <= -(W+1)'(d_r20);
      ya_x_r <= $signed({1'b0, sy});
      za_y_r <= (W+1)'(r10_d_r[W+1]);
      za_x_r <= (W+1)'(r00_d_r[W+1]);
    end
  end

  // angle units
  logic signed [W-1:0] ax, ay, az;
  rme_cordic #(.W(W)) u_cx (.clk(clk), .en(en), .y_i(xa_y_r), .x_i(xa_x_r), .angle_o(ax));
  rme_cordic #(.W(W)) u_cy (.clk(clk), .en(en), .y_i(ya_y_r), .x_i(ya_x_r), .angle_o(ay));
  rme_cordic #(.W(W)) u_cz (.clk(clk), .en(en), .y_i(za_y_r), .x_i(za_x_r), .angle_o(az));

  // singular flag follows the cordic latency
  logic [CL-1:0] sing_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sing_d_r <= {sing_d_r[CL-2:0], sing_r};
    end
  end

  assign out_valid    = v_r[L-1];
  assign out_singular = sing_d_r[CL-1];
  assign out_angle_x  = ax;
  assign out_angle_y  = ay;
  assign out_angle_z  = sing_d_r[CL-1] ? '0 : az;

endmodule

@@ tb/sv/rotation_matrix_to_euler_tb.sv @@
// self-checking testbench for the rotation matrix to euler angle block
module rotation_matrix_to_euler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam int LATENCY = W + 29;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRESHIFT = rme_pkg::PRESHIFT_BASE - W;
  localparam int ROUND_SHIFT = rme_pkg::ANGLE_FRAC - (W - 3);
  localparam int TW = rme_pkg::THRESH_W;

  typedef struct {
    logic signed [W-1:0] r00, r10, r20, r21, r22, r11, r12;
  } matrix_t;

  typedef struct {
    logic signed [W-1:0] ax, ay, az;
    logic                sing;
  } euler_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] in_r00 = '0, in_r10 = '0, in_r20 = '0, in_r21 = '0;
  logic signed [W-1:0] in_r22 = '0, in_r11 = '0, in_r12 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_angle_x, out_angle_y, out_angle_z;
  logic out_singular;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [rme_pkg::PADDR_W-1:0] cfg_paddr = '0;
  logic [rme_pkg::PDATA_W-1:0] cfg_pwdata = '0;
  logic [rme_pkg::PDATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  rotation_matrix_to_euler #(.DATA_WIDTH(W)) dut (.*);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix_t pending_words[$];
  euler_t  expected_angles[$];
  logic [TW-1:0] threshold = rme_pkg::THRESH_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int cycles = 0;

  // floor square root of a nonnegative integer
  function automatic longint sqrt_floor(longint n);
    longint root, bit_v;
    root = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n = n - root - bit_v;
        root = (root >>> 1) + bit_v;
      end else begin
        root = root >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return root;
  endfunction

  // cordic vectoring atan2, rounded to the output lsb
  function automatic logic signed [W-1:0] angle_atan2(longint y, longint x);
    longint z, xs, ys, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(rme_pkg::PI_Q24) : -longint'(rme_pkg::PI_Q24);
      x = -x;
      y = -y;
    end
    xs = x <<< PRESHIFT;
    ys = y <<< PRESHIFT;
    for (int i = 0; i < rme_pkg::CORDIC_STAGES; i++) begin
      if (ys == 0) break;
      dx = ys >>> i;
      dy = xs >>> i;
      if (ys > 0) begin
        xs = xs + dx;
        ys = ys - dy;
        z = z + longint'(rme_pkg::atan_q24(i));
      end else begin
        xs = xs - dx;
        ys = ys + dy;
        z = z - longint'(rme_pkg::atan_q24(i));
      end
    end
    z = (z + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    return z[W-1:0];
  endfunction

  // expected angles for one matrix under the current threshold
  function automatic euler_t euler_predict(matrix_t m);
    euler_t e;
    longint sy;
    sy = sqrt_floor(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
    e.sing = (sy < longint'(threshold));
    e.ay = angle_atan2(-longint'(m.r20), sy);
    if (!e.sing) begin
      e.ax = angle_atan2(m.r21, m.r22);
      e.az = angle_atan2(m.r10, m.r00);
    end else begin
      e.ax = angle_atan2(-longint'(m.r12), m.r11);
      e.az = '0;
    end
    return e;
  endfunction

  // driver: predict on acceptance, then offer the next pending word
  always @(posedge clk) begin
    matrix_t m;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_angles.push_back(euler_predict('{in_r00, in_r10, in_r20, in_r21, in_r22,
                                                   in_r11, in_r12}));
      if (!(in_valid && in_stall)) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          m = pending_words.pop_front();
          in_r00 <= m.r00; in_r10 <= m.r10; in_r20 <= m.r20; in_r21 <= m.r21;
          in_r22 <= m.r22; in_r11 <= m.r11; in_r12 <= m.r12;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    euler_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected word x=%0d y=%0d z=%0d s=%0b", $time,
                   out_angle_x, out_angle_y, out_angle_z, out_singular);
          errors++;
        end else begin
          e = expected_angles.pop_front();
          if (e.ax !== out_angle_x || e.ay !== out_angle_y || e.az !== out_angle_z ||
              e.sing !== out_singular) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d s=%0b %s",
                     $time, e.ax, e.ay, e.az, e.sing,
                     $sformatf("actual x=%0d y=%0d z=%0d s=%0b",
                               out_angle_x, out_angle_y, out_angle_z, out_singular));
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // apb write of the threshold register
  task automatic write_threshold(logic [TW-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= rme_pkg::PADDR_W'(rme_pkg::REG_THRESHOLD) << 2;
    cfg_pwdata <= rme_pkg::PDATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    threshold = value;
  endtask

  function automatic logic signed [W-1:0] rand_entry(int kind);
    case (kind)
      0: return W'($urandom_range(128) - 64);
      1: return W'($urandom_range(32768) - 16384);
      default: return W'($urandom_range(65535));
    endcase
  endfunction

  // random word: small column-0 entries reach the singular branch
  function automatic matrix_t random_matrix();
    matrix_t m;
    int k;
    k = $urandom_range(2);
    m.r00 = rand_entry(k);
    m.r10 = rand_entry(k);
    m.r20 = rand_entry($urandom_range(2));
    m.r21 = rand_entry($urandom_range(2));
    m.r22 = rand_entry($urandom_range(2));
    m.r11 = rand_entry($urandom_range(2));
    m.r12 = rand_entry($urandom_range(2));
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_angles.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // stimulus
  initial begin
    logic [TW-1:0] thr_plan[6];
    thr_plan = '{rme_pkg::THRESH_RESET, 15'd0, 15'd32767, 15'd16384, 15'd64, 15'd1};
    thr_plan[3] = TW'($urandom_range(32767));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed words: extremes, zero operands, axis cases, identity
    pending_words.push_back('{0, 0, 0, 0, 0, 0, 0});
    pending_words.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767});
    pending_words.push_back('{-32768, -32768, -32768, -32768, -32768, -32768, -32768});
    pending_words.push_back('{16384, 0, 0, 0, 16384, 16384, 0});
    pending_words.push_back('{0, 0, -16384, 0, 0, 16384, 0});
    pending_words.push_back('{0, 0, 16384, 0, 0, 0, 16384});
    pending_words.push_back('{0, 0, 0, 0, 0, -16384, -32768});
    pending_words.push_back('{-16384, 0, 0, 16384, 0, 0, 0});
    pending_words.push_back('{-16384, -1, 0, -16384, 0, 0, 0});
    pending_words.push_back('{0, 16384, 0, 5, -7, 0, 0});
    pending_words.push_back('{0, -16384, 32767, -3, -1, 0, 0});
    pending_words.push_back('{1, 0, -1, 1, 1, -1, 1});
    pending_words.push_back('{-32768, 32767, -32768, 32767, -32768, 32767, -32768});
    pending_words.push_back('{32767, -32768, 32767, -32768, 32767, -32768, 32767});

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 18; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (p > 0) write_threshold(thr_plan[p]);
      for (int i = 0; i < 310; i++) pending_words.push_back(random_matrix());
      wait_drained();
      repeat (LATENCY) @(posedge clk);
    end

    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ rotation_matrix_to_euler.f @@
sv/rme_pkg.sv
sv/rme_sqrt.sv
sv/rme_cordic.sv
sv/rotation_matrix_to_euler.sv
tb/sv/rotation_matrix_to_euler_tb.sv
